[rtl/output_select_by_overlap_assert.svh]
// Assertion macros for the output selection block.
// Used by the top level; enabled unless SYNTH is defined.
`ifndef OUTPUT_SELECT_BY_OVERLAP_ASSERT_SVH
`define OUTPUT_SELECT_BY_OVERLAP_ASSERT_SVH
`ifndef SYNTH
`define OSBO_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define OSBO_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define OSBO_ASSERT_SAME(label, clk, rst, ante, cons)
`define OSBO_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/osbo_pkg.sv]
// Shared types and constants of the output selection block.
// No dependencies.
package osbo_pkg;

  localparam int COORD_W = 15;
  localparam int DIVD_W  = 17;
  localparam int REM_W   = 16;
  localparam int GEO_W   = 19;
  localparam int OV_W    = 15;
  localparam int AREA_W  = 30;

  localparam logic [1:0] STRAT_SMART   = 2'd0;
  localparam logic [1:0] STRAT_LARGER  = 2'd1;
  localparam logic [1:0] STRAT_SMALLER = 2'd2;

  localparam logic [1:0] CFG_SCREEN_W = 2'd0;
  localparam logic [1:0] CFG_SCREEN_H = 2'd1;
  localparam logic [1:0] CFG_STRATEGY = 2'd2;
  localparam logic [1:0] CFG_COUNT    = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {ST_IDLE, ST_MOD, ST_SCAN, ST_FIN} state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] w;
    logic [COORD_W-1:0] h;
  } entry_t;

endpackage

[rtl/osbo_mod.sv]
// Bit-serial truncating remainder of a signed dividend by an unsigned divisor.
// Depends on osbo_pkg.
module osbo_mod (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [osbo_pkg::DIVD_W-1:0]  dividend,
  input  logic [osbo_pkg::COORD_W-1:0]        divisor,
  output logic                                done,
  output logic signed [osbo_pkg::REM_W-1:0]   remainder
);

  logic [osbo_pkg::DIVD_W-1:0]  mag;
  logic [osbo_pkg::COORD_W-1:0] rem;
  logic [osbo_pkg::COORD_W-1:0] dvs;
  logic [4:0]                   cnt;
  logic                         neg;
  logic                         run;
  logic [osbo_pkg::COORD_W:0]   trial;
  logic                         ge;

  assign trial = {rem, mag[osbo_pkg::DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= 5'(osbo_pkg::DIVD_W);
        neg <= dividend[osbo_pkg::DIVD_W-1];
        mag <= dividend[osbo_pkg::DIVD_W-1] ? -dividend : dividend;
        rem <= '0;
        dvs <= divisor;
      end else if (run) begin
        rem <= ge ? osbo_pkg::COORD_W'(trial - {1'b0, dvs})
                  : trial[osbo_pkg::COORD_W-1:0];
        mag <= {mag[osbo_pkg::DIVD_W-2:0], 1'b0};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = neg ? -$signed({1'b0, rem}) : $signed({1'b0, rem});

endmodule

[rtl/osbo_table.sv]
// Output rectangle table: one write port, one registered read port.
// Depends on osbo_pkg.
module osbo_table #(
  parameter int DEPTH = 16,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  osbo_pkg::entry_t     wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output osbo_pkg::entry_t     rdata
);

  osbo_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/output_select_by_overlap.sv]
// Output selection by overlap: a table write answers in the cycle after
// acceptance, as does a query with one output in use; any other query runs
// through the serial remainder, the geometry, one table read per entry
// through a three-stage scan, and the answer. One item at a time; the
// receiver cannot stall. Reset sets the registers to 1920, 1080, 1, 1; the
// table is not cleared.
module output_select_by_overlap #(
  parameter int MAX_OUTPUTS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               action,
  input  logic [3:0]                         entry_index,
  input  logic signed [15:0]                 pos_x,
  input  logic signed [15:0]                 pos_y,
  input  logic [14:0]                        size_w,
  input  logic [14:0]                        size_h,
  input  logic [7:0]                         border,
  output logic                               done,
  output logic [3:0]                         chosen_output,
  output logic                               was_query,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [14:0]                        cfg_data
);

  localparam int IDX_W = $clog2(MAX_OUTPUTS);
  localparam int CNT_W = $clog2(MAX_OUTPUTS + 1);
  localparam int GW    = osbo_pkg::GEO_W;

  osbo_pkg::state_t state, state_next;

  logic [14:0] scr_w, scr_h;
  logic [1:0]  strategy;
  logic [4:0]  count;
  logic [14:0] sw_eff, sh_eff;
  logic [CNT_W-1:0] n_eff, n_q;

  logic accept, query_start, direct_resp;
  logic q_smart, q_larger;
  logic [15:0] gw_q, gh_q;
  logic signed [GW-1:0] gx_q, gy_q;
  logic signed [GW-1:0] gx_next, gy_next;
  logic signed [osbo_pkg::DIVD_W-1:0] dvd_x, dvd_y;
  logic mx_done, my_done;
  logic signed [osbo_pkg::REM_W-1:0] rem_x, rem_y;

  logic [CNT_W-1:0] issue_cnt;
  logic issuing, scan_done, mod_finish;
  logic rd_v, s1_v, s2_v;
  logic [IDX_W-1:0] rd_idx, s1_idx, s2_idx;
  osbo_pkg::entry_t rdata, wdata;
  logic [osbo_pkg::OV_W-1:0] ovx, ovy, ovx_next, ovy_next;
  logic [14:0] s1_w, s1_h;
  logic [osbo_pkg::AREA_W-1:0] s2_area, s2_sz;
  logic [osbo_pkg::AREA_W-1:0] best, tsize;
  logic [IDX_W-1:0] pick, tpick;
  logic [1:0] seen;
  logic tinit, fit0, fit;

  assign cfg_ready = 1'b1;
  assign sw_eff = (scr_w == '0) ? 15'd1 : scr_w;
  assign sh_eff = (scr_h == '0) ? 15'd1 : scr_h;
  assign n_eff  = (count == '0) ? CNT_W'(1) :
                  (int'(count) > MAX_OUTPUTS) ? CNT_W'(MAX_OUTPUTS) : CNT_W'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      scr_w    <= 15'd1920;
      scr_h    <= 15'd1080;
      strategy <= osbo_pkg::STRAT_LARGER;
      count    <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        osbo_pkg::CFG_SCREEN_W: scr_w    <= cfg_data;
        osbo_pkg::CFG_SCREEN_H: scr_h    <= cfg_data;
        osbo_pkg::CFG_STRATEGY: strategy <= cfg_data[1:0];
        osbo_pkg::CFG_COUNT:    count    <= cfg_data[4:0];
      endcase
    end
  end

  assign accept      = start && !busy;
  assign query_start = accept && (action == osbo_pkg::ACT_QUERY) && (n_eff != CNT_W'(1));
  assign direct_resp = accept && !query_start;

  assign wdata = '{x: pos_x[14:0], y: pos_y[14:0], w: size_w, h: size_h};

  always_comb begin
    if (strategy == osbo_pkg::STRAT_SMART) begin
      dvd_x = {pos_x[15], pos_x};
      dvd_y = {pos_y[15], pos_y};
    end else begin
      dvd_x = {pos_x[15], pos_x} + $signed({3'b0, size_w[14:1]}) + $signed({9'b0, border});
      dvd_y = {pos_y[15], pos_y} + $signed({3'b0, size_h[14:1]}) + $signed({9'b0, border});
    end
  end

  osbo_mod u_mod_x (.clk, .rst, .start(query_start), .dividend(dvd_x), .divisor(sw_eff),
                    .done(mx_done), .remainder(rem_x));
  osbo_mod u_mod_y (.clk, .rst, .start(query_start), .dividend(dvd_y), .divisor(sh_eff),
                    .done(my_done), .remainder(rem_y));

  always_comb begin
    logic signed [GW-1:0] vx, vy, cx, cy, swx, shy;
    vx  = GW'(rem_x);
    vy  = GW'(rem_y);
    swx = $signed({4'b0, sw_eff});
    shy = $signed({4'b0, sh_eff});
    cx  = vx + $signed({4'b0, gw_q[15:1]});
    cy  = vy + $signed({4'b0, gh_q[15:1]});
    if (q_smart) begin
      gx_next = (cx < 0) ? vx + swx : (cx > swx) ? vx - swx : vx;
      gy_next = (cy < 0) ? vy + shy : (cy > shy) ? vy - shy : vy;
    end else begin
      gx_next = (vx < 0) ? vx + swx : vx;
      gy_next = (vy < 0) ? vy + shy : vy;
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      q_smart  <= strategy == osbo_pkg::STRAT_SMART;
      q_larger <= strategy != osbo_pkg::STRAT_SMALLER;
      n_q      <= n_eff;
      if (strategy == osbo_pkg::STRAT_SMART) begin
        gw_q <= {1'b0, size_w} + {7'b0, border, 1'b0};
        gh_q <= {1'b0, size_h} + {7'b0, border, 1'b0};
      end else begin
        gw_q <= 16'd1;
        gh_q <= 16'd1;
      end
    end
    if (mod_finish) begin
      gx_q <= gx_next;
      gy_q <= gy_next;
    end
  end

  osbo_table #(.DEPTH(MAX_OUTPUTS)) u_table (
    .clk,
    .we(accept && (action == osbo_pkg::ACT_WRITE) && (int'(entry_index) < MAX_OUTPUTS)),
    .waddr(IDX_W'(entry_index)),
    .wdata,
    .re(issuing),
    .raddr(issue_cnt[IDX_W-1:0]),
    .rdata
  );

  always_comb begin
    logic signed [GW-1:0] ox, oy, lo, hi, oxe, oye, gxe, gye;
    ox  = $signed({4'b0, rdata.x});
    oy  = $signed({4'b0, rdata.y});
    oxe = ox + $signed({4'b0, rdata.w});
    oye = oy + $signed({4'b0, rdata.h});
    gxe = gx_q + $signed({3'b0, gw_q});
    gye = gy_q + $signed({3'b0, gh_q});
    lo  = (ox > gx_q) ? ox : gx_q;
    hi  = (oxe < gxe) ? oxe : gxe;
    ovx_next = (hi > lo) ? osbo_pkg::OV_W'(hi - lo) : '0;
    lo  = (oy > gy_q) ? oy : gy_q;
    hi  = (oye < gye) ? oye : gye;
    ovy_next = (hi > lo) ? osbo_pkg::OV_W'(hi - lo) : '0;
  end

  assign fit0 = q_larger ? (s2_sz != '0) : 1'b1;
  assign fit  = tinit ? fit0 : (q_larger ? (s2_sz > tsize) : (s2_sz < tsize));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      rd_v <= issuing;
      s1_v <= rd_v;
      s2_v <= s1_v;
    end
    rd_idx  <= issue_cnt[IDX_W-1:0];
    s1_idx  <= rd_idx;
    s2_idx  <= s1_idx;
    ovx     <= ovx_next;
    ovy     <= ovy_next;
    s1_w    <= rdata.w;
    s1_h    <= rdata.h;
    s2_area <= osbo_pkg::AREA_W'(ovx) * osbo_pkg::AREA_W'(ovy);
    s2_sz   <= osbo_pkg::AREA_W'(s1_w) * osbo_pkg::AREA_W'(s1_h);
    if (mod_finish) begin
      issue_cnt <= '0;
      best      <= '0;
      pick      <= '0;
      seen      <= '0;
      tpick     <= '0;
      tinit     <= 1'b1;
      tsize     <= '0;
    end else begin
      if (issuing) begin
        issue_cnt <= issue_cnt + CNT_W'(1);
      end
      if (s2_v) begin
        if (s2_area > best) begin
          best  <= s2_area;
          pick  <= s2_idx;
          seen  <= 2'd1;
          tpick <= fit0 ? s2_idx : '0;
          tsize <= s2_sz;
          tinit <= !fit0;
        end else if (s2_area == best) begin
          seen <= (seen == 2'd2) ? 2'd2 : seen + 2'd1;
          if (fit) begin
            tpick <= s2_idx;
            tsize <= s2_sz;
            tinit <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osbo_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= direct_resp || (state == osbo_pkg::ST_FIN);
    end
    if (direct_resp) begin
      chosen_output <= 4'd0;
      was_query     <= action;
    end else if (state == osbo_pkg::ST_FIN) begin
      chosen_output <= 4'((seen == 2'd2) ? tpick : pick);
      was_query     <= 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      osbo_pkg::ST_IDLE: if (query_start) state_next = osbo_pkg::ST_MOD;
      osbo_pkg::ST_MOD:  if (mx_done) state_next = osbo_pkg::ST_SCAN;
      osbo_pkg::ST_SCAN: if (scan_done) state_next = osbo_pkg::ST_FIN;
      osbo_pkg::ST_FIN:  state_next = osbo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = state != osbo_pkg::ST_IDLE;
    mod_finish = (state == osbo_pkg::ST_MOD) && mx_done;
    issuing    = (state == osbo_pkg::ST_SCAN) && (issue_cnt < n_q);
    scan_done  = (state == osbo_pkg::ST_SCAN) && (issue_cnt == n_q) && !rd_v && !s1_v && !s2_v;
  end

`include "output_select_by_overlap_assert.svh"

  `OSBO_ASSERT_SAME(a_done_idle, clk, rst, done, !busy)
  `OSBO_ASSERT_SAME(a_mod_pair, clk, rst, mx_done, my_done)
  `OSBO_ASSERT_SAME(a_scan_only, clk, rst, s2_v, state == osbo_pkg::ST_SCAN)
  `OSBO_ASSERT_NEXT(a_query_goes, clk, rst, start && !busy && action, busy || done)

endmodule
